// ===== hdl/bmrt_pkg.sv =====
// Package for the binned minimum record tracker.
// Holds the command, status and register codes and the record type; no dependencies.
`timescale 1ns / 1ps
package bmrt_pkg;
    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_READ   = 1'b1;

    localparam logic [1:0] ST_NEW  = 2'd0;
    localparam logic [1:0] ST_KEPT = 2'd1;
    localparam logic [1:0] ST_ERR  = 2'd2;
    localparam logic [1:0] ST_READ = 2'd3;

    localparam logic [1:0] REG_WIDTH = 2'd0;
    localparam logic [1:0] REG_MIN   = 2'd1;
    localparam logic [1:0] REG_BINS  = 2'd2;

    typedef struct packed {
        logic [47:0] area;
        logic [47:0] vol;
        logic [7:0]  ls;
        logic [7:0]  lb;
        logic [31:0] rs;
        logic [31:0] rb;
        logic [31:0] rg;
        logic [31:0] energy;
    } rec_t;
endpackage

// ===== hdl/bmrt_front.sv =====
// Front end: accepts words, computes the bin by serial division, range checks.
// Depends on bmrt_pkg.
`timescale 1ns / 1ps
module bmrt_front #(
    parameter int BINS = 1024,
    parameter int BW = 10
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic                 command,
    input  logic [23:0]          particle_count,
    input  bmrt_pkg::rec_t       in_rec,
    input  logic [9:0]           read_bin,
    input  logic [15:0]          bin_width,
    input  logic [23:0]          min_count,
    input  logic [10:0]          bins_in_use,
    output logic                 q_valid,
    input  logic                 q_ready,
    output logic                 q_cmd,
    output logic                 q_err,
    output logic [BW-1:0]        q_bin,
    output logic [9:0]           q_idx,
    output bmrt_pkg::rec_t       q_rec
);
    import bmrt_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DIV1 = 3'd1;
    localparam logic [2:0] S_RND  = 3'd2;
    localparam logic [2:0] S_DIV2 = 3'd3;
    localparam logic [2:0] S_CHK  = 3'd4;
    localparam logic [2:0] S_OUT  = 3'd5;

    logic [2:0]  state_reg, state_next;
    logic [23:0] quo_reg;
    logic [24:0] rem_reg;
    logic [24:0] num_reg;
    logic [4:0]  cnt_reg;
    logic        cmd_reg, err_reg;
    logic [9:0]  rbin_reg;
    rec_t        rec_reg;
    logic [16:0] w;
    logic [25:0] trial;
    logic [41:0] prod;
    logic [16:0] lim;

    assign w = (bin_width == 16'd0) ? 17'd1 : {1'b0, bin_width};
    assign lim = ({6'd0, bins_in_use} > 17'(BINS)) ? 17'(BINS) : {6'd0, bins_in_use};
    assign trial = {rem_reg, num_reg[24]} - {9'd0, w};
    assign prod = {18'd0, quo_reg} * {25'd0, w};
    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: if (in_valid) state_next = command ? S_CHK : S_DIV1;
            S_DIV1: if (cnt_reg == 5'd0) state_next = S_RND;
            S_RND:  state_next = S_DIV2;
            S_DIV2: if (cnt_reg == 5'd0) state_next = S_CHK;
            S_CHK:  state_next = S_OUT;
            S_OUT:  if (q_ready) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_IDLE:
            begin
                cmd_reg  <= command;
                rec_reg  <= in_rec;
                rbin_reg <= read_bin;
                num_reg  <= {1'b0, particle_count};
                rem_reg  <= 25'd0;
                quo_reg  <= 24'd0;
                cnt_reg  <= 5'd24;
                err_reg  <= 1'b0;
            end
            S_DIV1, S_DIV2:
            begin
                if (!trial[25])
                begin
                    rem_reg <= trial[24:0];
                    quo_reg <= {quo_reg[22:0], 1'b1};
                end
                else
                begin
                    rem_reg <= {rem_reg[23:0], num_reg[24]};
                    quo_reg <= {quo_reg[22:0], 1'b0};
                end
                num_reg <= {num_reg[23:0], 1'b0};
                cnt_reg <= cnt_reg - 5'd1;
            end
            S_RND:
            begin
                // rounded = (q + half) * w, minus min_count, divide again
                if ({rem_reg[23:0], 1'b0} >= {8'd0, w})
                begin
                    if (prod + {25'd0, w} < {18'd0, min_count}) err_reg <= 1'b1;
                    num_reg <= 25'(prod + {25'd0, w} - {18'd0, min_count});
                end
                else
                begin
                    if (prod < {18'd0, min_count}) err_reg <= 1'b1;
                    num_reg <= 25'(prod - {18'd0, min_count});
                end
                rem_reg <= 25'd0;
                quo_reg <= 24'd0;
                cnt_reg <= 5'd24;
            end
            S_CHK:
            begin
                if (cmd_reg == CMD_READ)
                begin
                    err_reg <= ({7'd0, rbin_reg} >= lim);
                    quo_reg <= {14'd0, rbin_reg};
                end
                else if ({1'b0, quo_reg} >= {8'd0, lim})
                begin
                    err_reg <= 1'b1;
                end
            end
            default: ;
        endcase
    end

    assign q_valid = (state_reg == S_OUT);
    assign q_cmd   = cmd_reg;
    assign q_err   = err_reg;
    assign q_bin   = BW'(quo_reg);
    assign q_idx   = quo_reg[9:0];
    assign q_rec   = rec_reg;
endmodule

// ===== hdl/bmrt_back.sv =====
// Back end: bin store read-modify-write and result register.
// Depends on bmrt_pkg.
`timescale 1ns / 1ps
module bmrt_back #(
    parameter int BINS = 1024,
    parameter int BW = 10
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 q_valid,
    output logic                 q_ready,
    input  logic                 q_cmd,
    input  logic                 q_err,
    input  logic [BW-1:0]        q_bin,
    input  logic [9:0]           q_idx,
    input  bmrt_pkg::rec_t       q_rec,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [9:0]           o_idx,
    output logic [1:0]           o_status,
    output logic [23:0]          o_count,
    output bmrt_pkg::rec_t       o_rec
);
    import bmrt_pkg::*;

    localparam logic [1:0] B_CLR  = 2'd0;
    localparam logic [1:0] B_IDLE = 2'd1;
    localparam logic [1:0] B_RD   = 2'd2;
    localparam logic [1:0] B_WR   = 2'd3;

    logic [1:0]    state_reg;
    logic [BW-1:0] addr_reg;
    logic [BW:0]   clr_reg;
    logic [23:0]   cnt_mem [BINS];
    rec_t          rec_mem [BINS];
    logic [23:0]   cnt_rd;
    rec_t          rec_rd;
    logic          cmd_reg;
    logic [9:0]    idx_reg;
    rec_t          in_reg;
    logic          repl;
    logic [23:0]   cnt_new;

    assign q_ready = (state_reg == B_IDLE) && !out_valid;
    assign repl = (cnt_rd == 24'd0) || ($signed(in_reg.energy) <= $signed(rec_rd.energy));
    assign cnt_new = (cnt_rd == 24'hFFFFFF) ? cnt_rd : cnt_rd + 24'd1;

    always_ff @(posedge clk)
    begin
        if (state_reg == B_CLR)
        begin
            cnt_mem[clr_reg[BW-1:0]] <= 24'd0;
        end
        else if (state_reg == B_WR && cmd_reg == CMD_INSERT)
        begin
            cnt_mem[addr_reg] <= cnt_new;
            if (repl) rec_mem[addr_reg] <= in_reg;
        end
        if (state_reg == B_IDLE)
        begin
            cnt_rd <= cnt_mem[q_bin];
            rec_rd <= rec_mem[q_bin];
            addr_reg <= q_bin;
            cmd_reg <= q_cmd;
            idx_reg <= q_idx;
            in_reg <= q_rec;
        end
        if (q_valid && q_ready && q_err)
        begin
            o_idx <= 10'd0;
            o_status <= ST_ERR;
            o_count <= 24'd0;
            o_rec <= '0;
        end
        else if (state_reg == B_WR)
        begin
            o_idx <= idx_reg;
            if (cmd_reg == CMD_READ)
            begin
                o_status <= ST_READ;
                o_count <= cnt_rd;
                o_rec <= (cnt_rd == 24'd0) ? '0 : rec_rd;
            end
            else
            begin
                o_status <= repl ? ST_NEW : ST_KEPT;
                o_count <= cnt_new;
                o_rec <= repl ? in_reg : rec_rd;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= B_CLR;
            clr_reg <= '0;
            out_valid <= 1'b0;
        end
        else
        begin
            if (out_valid && out_ready) out_valid <= 1'b0;
            unique case (state_reg)
                B_CLR:
                begin
                    clr_reg <= clr_reg + 1'b1;
                    if (clr_reg == (BW+1)'(BINS - 1)) state_reg <= B_IDLE;
                end
                B_IDLE:
                begin
                    if (q_valid && q_ready)
                    begin
                        if (q_err) out_valid <= 1'b1;
                        else state_reg <= B_RD;
                    end
                end
                B_RD: state_reg <= B_WR;
                B_WR:
                begin
                    out_valid <= 1'b1;
                    state_reg <= B_IDLE;
                end
                default: state_reg <= B_IDLE;
            endcase
        end
    end
endmodule

// ===== hdl/binned_minimum_record_tracker.sv =====
// Top level of the binned minimum record tracker.
// Joins bmrt_front and bmrt_back; depends on bmrt_pkg.
`timescale 1ns / 1ps
// An insert runs two bit-serial divisions in the front end; a read skips them. After
// reset the back end clears the bin counts, one bin per cycle, before it takes the
// first word.
module binned_minimum_record_tracker #(
    parameter int BINS = 1024
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [23:0] cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        command,
    input  logic [23:0] particle_count,
    input  logic [31:0] free_energy,
    input  logic [31:0] growth_radius,
    input  logic [31:0] base_radius,
    input  logic [31:0] secondary_radius,
    input  logic [7:0]  base_layers,
    input  logic [7:0]  secondary_layers,
    input  logic [47:0] cluster_volume,
    input  logic [47:0] surface_area,
    input  logic [9:0]  read_bin,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [9:0]  bin_index,
    output logic [1:0]  status,
    output logic [23:0] bin_count,
    output logic [31:0] min_energy,
    output logic [31:0] best_growth_radius,
    output logic [31:0] best_base_radius,
    output logic [31:0] best_secondary_radius,
    output logic [7:0]  best_base_layers,
    output logic [7:0]  best_secondary_layers,
    output logic [47:0] best_volume,
    output logic [47:0] best_area
);
    import bmrt_pkg::*;

    localparam int BW = (BINS > 1) ? $clog2(BINS) : 1;

    logic [15:0] bin_width_reg;
    logic [23:0] min_count_reg;
    logic [10:0] bins_in_use_reg;
    rec_t in_rec, q_rec, o_rec;
    logic q_valid, q_ready, q_cmd, q_err;
    logic [BW-1:0] q_bin;
    logic [9:0] q_idx;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bin_width_reg <= 16'd1;
            min_count_reg <= 24'd0;
            bins_in_use_reg <= 11'd1024;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_WIDTH: bin_width_reg <= cfg_data[15:0];
                REG_MIN:   min_count_reg <= cfg_data;
                REG_BINS:  bins_in_use_reg <= cfg_data[10:0];
                default: ;
            endcase
        end
    end

    assign in_rec = '{area: surface_area, vol: cluster_volume, ls: secondary_layers,
                      lb: base_layers, rs: secondary_radius, rb: base_radius,
                      rg: growth_radius, energy: free_energy};

    bmrt_front #(.BINS(BINS), .BW(BW)) u_front (
        .clk, .rst_n, .in_valid, .in_ready, .command, .particle_count, .in_rec,
        .read_bin, .bin_width(bin_width_reg), .min_count(min_count_reg),
        .bins_in_use(bins_in_use_reg), .q_valid, .q_ready, .q_cmd, .q_err,
        .q_bin, .q_idx, .q_rec
    );

    bmrt_back #(.BINS(BINS), .BW(BW)) u_back (
        .clk, .rst_n, .q_valid, .q_ready, .q_cmd, .q_err, .q_bin, .q_idx, .q_rec,
        .out_valid, .out_ready, .o_idx(bin_index), .o_status(status),
        .o_count(bin_count), .o_rec
    );

    assign min_energy = o_rec.energy;
    assign best_growth_radius = o_rec.rg;
    assign best_base_radius = o_rec.rb;
    assign best_secondary_radius = o_rec.rs;
    assign best_base_layers = o_rec.lb;
    assign best_secondary_layers = o_rec.ls;
    assign best_volume = o_rec.vol;
    assign best_area = o_rec.area;
endmodule

// ===== tb/tb_binned_minimum_record_tracker.sv =====
// Testbench for binned_minimum_record_tracker: a directed table, then random words.
// Checks every result against a fixed outcome or an in-bench bin store model; depends on bmrt_pkg.
`timescale 1ns / 1ps
module tb_binned_minimum_record_tracker;
    import bmrt_pkg::*;

    localparam int NBINS = 1024;
    localparam int WATCHDOG = 40000;
    localparam logic [1:0] REG_UNUSED = 2'd3;

    typedef struct {
        logic        cmd;
        logic [23:0] cnt;
        logic [31:0] energy;
        logic [31:0] rg, rb, rs;
        logic [7:0]  lb, ls;
        logic [47:0] vol, area;
        logic [9:0]  rbin;
    } word_t;

    typedef struct {
        logic [9:0]  idx;
        logic [1:0]  st;
        logic [23:0] cnt;
        rec_t        rec;
    } outcome_t;

    typedef enum logic { ROW_CFG, ROW_WORD } row_kind_t;

    typedef struct {
        row_kind_t   kind;
        logic [23:0] width, minc, nbins;
        word_t       w;
        logic        fixed;
        outcome_t    res;
    } row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [1:0] cfg_index = '0;
    logic [23:0] cfg_data = '0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic command = 1'b0;
    logic [23:0] particle_count = '0;
    logic [31:0] free_energy = '0, growth_radius = '0, base_radius = '0, secondary_radius = '0;
    logic [7:0] base_layers = '0, secondary_layers = '0;
    logic [47:0] cluster_volume = '0, surface_area = '0;
    logic [9:0] read_bin = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic [9:0] bin_index;
    logic [1:0] status;
    logic [23:0] bin_count;
    logic [31:0] min_energy, best_growth_radius, best_base_radius, best_secondary_radius;
    logic [7:0] best_base_layers, best_secondary_layers;
    logic [47:0] best_volume, best_area;

    binned_minimum_record_tracker #(.BINS(NBINS)) DUT (.*);

    always #10 clk = ~clk;

    logic [15:0] m_width = 16'd1;
    logic [23:0] m_minc = '0;
    logic [10:0] m_nbins = 11'd1024;
    logic [23:0] m_counts [NBINS];
    rec_t m_store [NBINS];

    outcome_t pending_results [$];
    int idle_in = 0, idle_out = 0;
    int errors = 0, idle_cycles = 0;
    int n_insert = 0, n_read = 0, n_err = 0, n_cfg = 0;

    function automatic outcome_t bin_update(word_t w);
        outcome_t o;
        int unsigned wd, lim, q, r, rounded, b;
        o = '{default: '0};
        wd = (m_width == 0) ? 1 : m_width;
        lim = (m_nbins > NBINS) ? NBINS : m_nbins;
        if (w.cmd == CMD_READ) begin
            b = w.rbin;
            if (b >= lim) begin
                o.st = ST_ERR;
                return o;
            end
            o.st = ST_READ;
        end else begin
            q = w.cnt / wd;
            r = w.cnt % wd;
            if (2 * r >= wd)
                q++;
            rounded = q * wd;
            if (rounded < m_minc) begin
                o.st = ST_ERR;
                return o;
            end
            b = (rounded - m_minc) / wd;
            if (b >= lim) begin
                o.st = ST_ERR;
                return o;
            end
            o.st = ST_KEPT;
            if (m_counts[b] == 0 || $signed(w.energy) <= $signed(m_store[b].energy)) begin
                m_store[b] = '{area: w.area, vol: w.vol, ls: w.ls, lb: w.lb,
                               rs: w.rs, rb: w.rb, rg: w.rg, energy: w.energy};
                o.st = ST_NEW;
            end
            if (m_counts[b] != 24'hFFFFFF)
                m_counts[b]++;
        end
        o.idx = b[9:0];
        o.cnt = m_counts[b];
        if (m_counts[b] != 0)
            o.rec = m_store[b];
        return o;
    endfunction

    task automatic write_reg(logic [1:0] idx, logic [23:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == REG_WIDTH)
            m_width = val[15:0];
        else if (idx == REG_MIN)
            m_minc = val;
        else if (idx == REG_BINS)
            m_nbins = val[10:0];
        n_cfg++;
    endtask

    task automatic set_config(logic [23:0] wd, logic [23:0] mc, logic [23:0] nb);
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (80) @(posedge clk);
        write_reg(REG_WIDTH, wd);
        write_reg(REG_MIN, mc);
        write_reg(REG_BINS, nb);
        write_reg(REG_UNUSED, 24'($urandom));
    endtask

    task automatic send_word(word_t w, logic fixed, outcome_t res);
        outcome_t p;
        while ($urandom_range(99) < idle_in)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        command <= w.cmd;
        particle_count <= w.cnt;
        free_energy <= w.energy;
        growth_radius <= w.rg;
        base_radius <= w.rb;
        secondary_radius <= w.rs;
        base_layers <= w.lb;
        secondary_layers <= w.ls;
        cluster_volume <= w.vol;
        surface_area <= w.area;
        read_bin <= w.rbin;
        do
            @(posedge clk);
        while (!in_ready);
        p = bin_update(w);
        if (p.st == ST_ERR)
            n_err++;
        else if (w.cmd == CMD_READ)
            n_read++;
        else
            n_insert++;
        pending_results = {pending_results, fixed ? res : p};
    endtask

    function automatic word_t rand_word();
        word_t w;
        w.cmd = 1'($urandom);
        w.cnt = 24'($urandom);
        w.energy = $urandom;
        w.rg = $urandom;
        w.rb = $urandom;
        w.rs = $urandom;
        w.lb = 8'($urandom);
        w.ls = 8'($urandom);
        w.vol = {16'($urandom), 32'($urandom)};
        w.area = {16'($urandom), 32'($urandom)};
        w.rbin = 10'($urandom);
        return w;
    endfunction

    task automatic check_field(string nm, logic [47:0] e, logic [47:0] a);
        if (e !== a) begin
            errors++;
            if (errors <= 10)
                $display("mismatch %s: expected %h, got %h", nm, e, a);
        end
    endtask

    always @(posedge clk) begin
        outcome_t e;
        if (rst_n && out_valid && out_ready) begin
            if (pending_results.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result word, bin %0d status %0d", bin_index, status);
            end else begin
                e = pending_results.pop_front();
                check_field("bin_index", 48'(e.idx), 48'(bin_index));
                check_field("status", 48'(e.st), 48'(status));
                check_field("bin_count", 48'(e.cnt), 48'(bin_count));
                check_field("min_energy", 48'(e.rec.energy), 48'(min_energy));
                check_field("best_growth_radius", 48'(e.rec.rg), 48'(best_growth_radius));
                check_field("best_base_radius", 48'(e.rec.rb), 48'(best_base_radius));
                check_field("best_secondary_radius", 48'(e.rec.rs),
                            48'(best_secondary_radius));
                check_field("best_base_layers", 48'(e.rec.lb), 48'(best_base_layers));
                check_field("best_secondary_layers", 48'(e.rec.ls),
                            48'(best_secondary_layers));
                check_field("best_volume", e.rec.vol, best_volume);
                check_field("best_area", e.rec.area, best_area);
            end
        end
        out_ready <= ($urandom_range(99) >= idle_out);
        if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    always @(posedge clk) begin
        if (idle_cycles >= WATCHDOG) begin
            $display("watchdog: no word moved in %0d cycles", WATCHDOG);
            $display("tb_binned_minimum_record_tracker: errors");
            $finish;
        end
    end

    function automatic row_t cfg_row(int wd, int mc, int nb);
        row_t r;
        r = '{kind: ROW_CFG, default: '0};
        r.width = 24'(wd);
        r.minc = 24'(mc);
        r.nbins = 24'(nb);
        return r;
    endfunction

    function automatic row_t word_row(logic cmd, int cnt, logic [31:0] en, int rbin);
        row_t r;
        r = '{kind: ROW_WORD, default: '0};
        r.w = rand_word();
        r.w.cmd = cmd;
        r.w.cnt = 24'(cnt);
        r.w.energy = en;
        r.w.rbin = 10'(rbin);
        r.fixed = 1'b0;
        return r;
    endfunction

    function automatic row_t fixed_row(logic cmd, int cnt, logic [31:0] en, int rbin,
                                       logic [1:0] st, int idx);
        row_t r;
        r = word_row(cmd, cnt, en, rbin);
        r.fixed = 1'b1;
        r.res.st = st;
        r.res.idx = 10'(idx);
        return r;
    endfunction

    initial begin
        row_t rows [$];
        row_t r;
        word_t w;
        int wd, mc, nb, span, b;
        foreach (m_counts[i])
            m_counts[i] = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        rows = {rows, fixed_row(CMD_READ, 0, 0, 0, ST_READ, 0)};
        rows = {rows, fixed_row(CMD_READ, 0, 0, 1023, ST_READ, 1023)};
        rows = {rows, word_row(CMD_INSERT, 5, 32'h7FFFFFFF, 0)};
        rows = {rows, word_row(CMD_INSERT, 5, 32'h80000000, 0)};
        rows = {rows, word_row(CMD_INSERT, 5, 32'h80000000, 0)};
        rows = {rows, word_row(CMD_INSERT, 5, 32'h00000001, 0)};
        rows = {rows, word_row(CMD_READ, 0, 0, 5)};
        r = word_row(CMD_INSERT, 1023, 32'hFFFFFFFF, 0);
        r.w = '{cmd: CMD_INSERT, cnt: 24'd1023, energy: '1, rg: '1, rb: '1, rs: '1,
                lb: '1, ls: '1, vol: '1, area: '1, rbin: '1};
        rows = {rows, r};
        rows = {rows, fixed_row(CMD_INSERT, 1024, 0, 0, ST_ERR, 0)};
        rows = {rows, fixed_row(CMD_INSERT, 24'hFFFFFF, 0, 0, ST_ERR, 0)};
        rows = {rows, word_row(CMD_INSERT, 0, 0, 0)};
        rows = {rows, cfg_row(10, 20, 4)};
        rows = {rows, fixed_row(CMD_INSERT, 14, 0, 0, ST_ERR, 0)};
        rows = {rows, word_row(CMD_INSERT, 15, 0, 0)};
        rows = {rows, word_row(CMD_INSERT, 24, 0, 0)};
        rows = {rows, word_row(CMD_INSERT, 25, 0, 0)};
        rows = {rows, word_row(CMD_INSERT, 54, 0, 0)};
        rows = {rows, fixed_row(CMD_INSERT, 55, 0, 0, ST_ERR, 0)};
        rows = {rows, fixed_row(CMD_READ, 0, 0, 4, ST_ERR, 0)};
        rows = {rows, word_row(CMD_READ, 0, 0, 3)};
        rows = {rows, cfg_row(0, 0, 0)};
        rows = {rows, fixed_row(CMD_INSERT, 3, 0, 0, ST_ERR, 0)};
        rows = {rows, fixed_row(CMD_READ, 0, 0, 0, ST_ERR, 0)};
        rows = {rows, cfg_row(65535, 0, 2047)};
        rows = {rows, word_row(CMD_INSERT, 32767, 0, 0)};
        rows = {rows, word_row(CMD_INSERT, 32768, 0, 0)};
        rows = {rows, word_row(CMD_INSERT, 24'hFFFFFF, 0, 0)};

        foreach (rows[i]) begin
            if (rows[i].kind == ROW_CFG)
                set_config(rows[i].width, rows[i].minc, rows[i].nbins);
            else
                send_word(rows[i].w, rows[i].fixed, rows[i].res);
        end

        for (int ph = 0; ph < 9; ph++) begin
            idle_in = (ph < 3) ? 18 : (ph < 6) ? 82 : 0;
            idle_out = (ph < 3) ? 82 : (ph < 6) ? 18 : 0;
            case (ph % 3)
                0: begin
                    wd = $urandom_range(1, 9);
                    nb = $urandom_range(1, 40);
                    mc = wd * $urandom_range(0, 100);
                end
                1: begin
                    wd = 1;
                    nb = 1024;
                    mc = (ph == 4) ? 24'hFFFFFF : 24'hFFFFFF - 1100;
                end
                default: begin
                    wd = (ph == 8) ? 65535 : $urandom_range(1000, 65535);
                    nb = (ph == 2) ? 1 : $urandom_range(2, 256);
                    mc = 0;
                end
            endcase
            set_config(24'(wd), 24'(mc), 24'(nb));
            span = (nb > 64) ? 64 : nb;
            for (int k = 0; k < 156; k++) begin
                w = rand_word();
                if ($urandom_range(99) < 80) begin
                    b = $urandom_range(0, span);
                    w.cnt = 24'(mc + b * wd + $signed($urandom_range(0, wd)) - wd / 2);
                    w.rbin = 10'($urandom_range(0, span));
                    if ($urandom_range(3) == 0)
                        w.energy = $signed($urandom_range(0, 7)) - 4;
                    w.cmd = ($urandom_range(99) < 25) ? CMD_READ : CMD_INSERT;
                end
                send_word(w, 1'b0, '{default: '0});
            end
        end

        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
        $display("covered %0d inserts, %0d reads, %0d out of range words", n_insert, n_read,
                 n_err);
        $display("across %0d register writes and three idling mixes", n_cfg);
        if (errors == 0)
            $display("tb_binned_minimum_record_tracker: clean");
        else
            $display("tb_binned_minimum_record_tracker: errors");
        $finish;
    end
endmodule
